/* src/three_wire_rtc_serial_master_unit_defines.svh */
// Assertion macros shared by the serial master RTL.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_UNIT_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_UNIT_DEFINES_SVH

// Check a same-cycle implication on the rising clock, off during reset.
`define TWRSM_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a property that starts in the cycle after the antecedent.
`define TWRSM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/twrsm_pkg.sv */
// Types and constants of the three-wire serial master.
`timescale 1ns / 1ps

package twrsm_pkg;

   // Tick counter width and configuration width
   localparam int TICK_COUNT_WIDTH = 8;
   localparam int CFG_W            = 8;
   localparam logic [CFG_W-1:0] HALF_RESET = 8'd2;

   // Action codes of an input item
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Command bit0 forcing masks
   localparam logic [7:0] CMD_READ_SET   = 8'h01;
   localparam logic [7:0] CMD_WRITE_MASK = 8'hFE;

   // Bit phases: data byte starts at 8, transaction ends after 15
   localparam logic [4:0] PHASE_DATA = 5'd8;
   localparam logic [4:0] PHASE_END  = 5'd16;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] command_byte;
      logic [7:0] write_data;
      logic       io_in;
   } twrsm_req_type;

   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_drive;
      logic       io_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } twrsm_rsp_type;

   // Classified item held in the queue
   typedef struct packed {
      logic        is_start;
      logic        is_read;
      logic [15:0] shift_word;
      logic        io_in;
   } twrsm_item_type;

   // Queue to engine handshake
   typedef struct packed {
      logic           valid;
      twrsm_item_type item;
   } twrsm_q_type;

endpackage

/* src/three_wire_rtc_serial_master_unit.sv */
// Path: a tick is written into the queue, then its result into the result register.
// Throughput: one tick per cycle while the queue is not full; the bit timer and shifters step once per tick.
// A two-entry queue parts the input side from the engine; the result register
// holds one finished tick while the next is taken.
// Synchronous active-high reset: engine idle, no result valid, half period back to two ticks.
`timescale 1ns / 1ps
`include "three_wire_rtc_serial_master_unit_defines.svh"

module three_wire_rtc_serial_master_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  twrsm_pkg::twrsm_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output twrsm_pkg::twrsm_rsp_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_wdata
);
   import twrsm_pkg::*;

   twrsm_q_type q_link;
   logic        q_pop;

   // Accept and classify ticks
   twrsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_link),
      .q_pop     (q_pop)
   );

   // Run the serial transaction
   twrsm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_link),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `TWRSM_ASSERT_SAME(a_done_ends, rsp_valid && rsp_data.done_res, !rsp_data.busy_res && !rsp_data.serial_clock, "done with busy or clock high")
   `TWRSM_ASSERT_SAME(a_idle_pins, rsp_valid && !rsp_data.busy_res, !rsp_data.chip_enable && !rsp_data.io_drive && !rsp_data.io_out, "pins active while idle")
   `TWRSM_ASSERT_NEXT(a_latency, req_valid && !req_stall && !q_link.valid && !rsp_valid, ##1 rsp_valid, "tick result missing after two cycles")

endmodule

/* src/twrsm_front.sv */
// Front end: classifies input items and queues them for the engine.
`timescale 1ns / 1ps

module twrsm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  twrsm_pkg::twrsm_req_type req_data,
   output twrsm_pkg::twrsm_q_type   q_out,
   input  logic                    q_pop
);
   import twrsm_pkg::*;

   twrsm_item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]           count_ff, count_in;
   twrsm_item_type              item_new;
   logic                        push;
   logic                        pop;

   // Classify the request and build the command/data shift word
   always_comb begin
      item_new.io_in = req_data.io_in;
      unique case (req_data.action)
         ACT_WRITE: begin
            item_new.is_start   = 1'b1;
            item_new.is_read    = 1'b0;
            item_new.shift_word = {req_data.write_data,
                                   req_data.command_byte & CMD_WRITE_MASK};
         end
         ACT_READ: begin
            item_new.is_start   = 1'b1;
            item_new.is_read    = 1'b1;
            item_new.shift_word = {8'h00, req_data.command_byte | CMD_READ_SET};
         end
         default: begin
            item_new.is_start   = 1'b0;
            item_new.is_read    = 1'b0;
            item_new.shift_word = 16'h0000;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

/* src/twrsm_engine.sv */
// Back end: bit timer, shift registers and the result register.
`timescale 1ns / 1ps

module twrsm_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  twrsm_pkg::twrsm_q_type   q_in,
   output logic                    q_pop,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output twrsm_pkg::twrsm_rsp_type rsp_data
);
   import twrsm_pkg::*;

   localparam int CMP_W = ((TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W) + 1;
   localparam logic [CMP_W-1:0] HALF_CAP = CMP_W'(1) << TICK_COUNT_WIDTH;

   logic [CFG_W-1:0]            half_ff;
   logic [4:0]                  bit_phase_ff, bit_phase_in;
   logic                        clock_level_ff, clock_level_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [15:0]                 out_shift_ff, out_shift_in;
   logic                        is_read_ff, is_read_in;
   logic                        active_ff, active_in;
   logic [7:0]                  in_shift_ff, in_shift_in;
   logic                        out_valid_ff;
   twrsm_rsp_type               rsp_ff, rsp_in;
   logic [CMP_W-1:0]            half_len;
   logic [CMP_W-1:0]            tick_next;
   logic [4:0]                  phase_next;
   logic                        done;
   logic                        drive;

   assign csr_ready = 1'b1;
   assign q_pop     = q_in.valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // Half length: zero counts as one, capped at the counter range
   always_comb begin
      half_len = (half_ff == '0) ? CMP_W'(1) : CMP_W'(half_ff);
      if (half_len > HALF_CAP) begin
         half_len = HALF_CAP;
      end
   end

   assign tick_next  = CMP_W'(tick_count_ff) + CMP_W'(1);
   assign phase_next = bit_phase_ff + 5'd1;

   // Step the transaction by one tick
   always_comb begin
      bit_phase_in   = bit_phase_ff;
      clock_level_in = clock_level_ff;
      tick_count_in  = tick_count_ff;
      out_shift_in   = out_shift_ff;
      is_read_in     = is_read_ff;
      active_in      = active_ff;
      in_shift_in    = in_shift_ff;
      done           = 1'b0;
      if (!active_ff) begin
         if (q_in.item.is_start) begin
            active_in      = 1'b1;
            is_read_in     = q_in.item.is_read;
            out_shift_in   = q_in.item.shift_word;
            bit_phase_in   = '0;
            clock_level_in = 1'b1;
            tick_count_in  = '0;
         end
      end else if (tick_next >= half_len) begin
         tick_count_in = '0;
         if (clock_level_ff) begin
            clock_level_in = 1'b0;
         end else if (phase_next >= PHASE_END) begin
            active_in      = 1'b0;
            done           = 1'b1;
            clock_level_in = 1'b0;
            bit_phase_in   = '0;
         end else begin
            clock_level_in = 1'b1;
            bit_phase_in   = phase_next;
            // sample the data line on the rising clock of a read data bit
            if (is_read_ff && phase_next >= PHASE_DATA) begin
               in_shift_in = {q_in.item.io_in, in_shift_ff[7:1]};
            end
         end
      end else begin
         tick_count_in = tick_next[TICK_COUNT_WIDTH-1:0];
      end
   end

   // Build the pin levels after this tick
   always_comb begin
      drive = active_in && !(is_read_in && bit_phase_in >= PHASE_DATA);
      rsp_in.chip_enable  = active_in;
      rsp_in.serial_clock = active_in && clock_level_in;
      rsp_in.io_drive     = drive;
      rsp_in.io_out       = drive && out_shift_in[bit_phase_in[3:0]];
      rsp_in.busy_res     = active_in;
      rsp_in.done_res     = done;
      rsp_in.read_data    = in_shift_in;
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         half_ff <= csr_wdata;
      end
   end

   // Transaction state advances only when a queued tick is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_phase_ff   <= '0;
         clock_level_ff <= 1'b0;
         tick_count_ff  <= '0;
         out_shift_ff   <= '0;
         is_read_ff     <= 1'b0;
         active_ff      <= 1'b0;
         in_shift_ff    <= '0;
      end else if (q_pop) begin
         bit_phase_ff   <= bit_phase_in;
         clock_level_ff <= clock_level_in;
         tick_count_ff  <= tick_count_in;
         out_shift_ff   <= out_shift_in;
         is_read_ff     <= is_read_in;
         active_ff      <= active_in;
         in_shift_ff    <= in_shift_in;
      end
   end

   // Result register: load on pop, drop when transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
